// ----- src/rkes_pkg.sv -----
// Shared types and constants for the record key exchange sorter.
// Used by the controller, the datapath and the top level; depends on nothing.
package rkes_pkg;

	localparam int KEY_W = 32;
	localparam int TAG_W = 6;
	localparam int REC_W = KEY_W + TAG_W;
	localparam int MAX_ITEMS_DEF = 64;

	typedef enum logic [2:0] {
		S_LOAD,
		S_FETCH,
		S_SCAN,
		S_STORE,
		S_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_en;    // write the record RAM
		logic wr_load;  // write data is the incoming record, else the held record
		logic load_cur; // read data of this cycle becomes the held record
		logic cmp;      // read data of this cycle is compared against the held record
		logic emit;     // read data of this cycle is a result
		logic last;     // that result closes the run
		logic ovf;      // records were dropped during loading
	} cmd_t;

endpackage

// ----- src/rkes_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Self-contained; instantiated by the sorter datapath.
module rkes_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/rkes_dp.sv -----
// Sorter datapath: record RAM, held record, key comparator, result registers.
// Depends on rkes_pkg and rkes_ram; driven by rkes_ctrl.
module rkes_dp #(
	parameter int MAX_ITEMS = rkes_pkg::MAX_ITEMS_DEF,
	localparam int AW = $clog2(MAX_ITEMS)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_desc,
	input  logic signed [rkes_pkg::KEY_W-1:0] key,
	input  logic        [rkes_pkg::TAG_W-1:0] tag,
	input  logic        [AW-1:0]             rd_addr,
	input  logic        [AW-1:0]             wr_addr,
	input  rkes_pkg::cmd_t                   cmd,
	output logic                             swap,
	output logic                             result_valid,
	output logic signed [rkes_pkg::KEY_W-1:0] sorted_key,
	output logic        [rkes_pkg::TAG_W-1:0] sorted_tag,
	output logic                             last_out,
	output logic                             overflowed
);

	logic                              desc_q;
	logic        [rkes_pkg::REC_W-1:0] cur_q;
	logic        [rkes_pkg::REC_W-1:0] wdata;
	logic        [rkes_pkg::REC_W-1:0] rdata;
	logic signed [rkes_pkg::KEY_W-1:0] cur_key;
	logic signed [rkes_pkg::KEY_W-1:0] rd_key;
	logic                              strobe_q;
	logic signed [rkes_pkg::KEY_W-1:0] key_q;
	logic        [rkes_pkg::TAG_W-1:0] tag_q;
	logic                              last_q;
	logic                              ovf_q;

	rkes_ram #(
		.WIDTH(rkes_pkg::REC_W),
		.DEPTH(MAX_ITEMS)
	) u_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(wr_addr),
		.wdata(wdata),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	assign wdata   = cmd.wr_load ? {key, tag} : cur_q;
	assign cur_key = cur_q[rkes_pkg::REC_W-1:rkes_pkg::TAG_W];
	assign rd_key  = rdata[rkes_pkg::REC_W-1:rkes_pkg::TAG_W];

	// In descending mode the xor also swaps equal keys.
	assign swap = cmd.cmp & ((cur_key > rd_key) ^ desc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				desc_q <= cfg_desc;
			end
			strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_cur || swap) begin
			cur_q <= rdata;
		end
		if (cmd.emit) begin
			key_q  <= rd_key;
			tag_q  <= rdata[rkes_pkg::TAG_W-1:0];
			last_q <= cmd.last;
			ovf_q  <= cmd.ovf;
		end
	end

	assign result_valid = strobe_q;
	assign sorted_key   = key_q;
	assign sorted_tag   = tag_q;
	assign last_out     = last_q;
	assign overflowed   = ovf_q;

endmodule

// ----- src/rkes_ctrl.sv -----
// Sorter controller: load, exchange-sort scan and emit sequencing.
// Depends on rkes_pkg; drives rkes_dp through addresses and a command struct.
module rkes_ctrl #(
	parameter int MAX_ITEMS = rkes_pkg::MAX_ITEMS_DEF,
	localparam int AW = $clog2(MAX_ITEMS),
	localparam int CW = $clog2(MAX_ITEMS + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           last,
	input  logic           swap,
	output logic           busy,
	output logic [AW-1:0]  rd_addr,
	output logic [AW-1:0]  wr_addr,
	output rkes_pkg::cmd_t cmd
);

	rkes_pkg::state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] n_q, n_d;
	logic [CW-1:0] i_q, i_d;
	logic [CW-1:0] j_q, j_d;
	logic          ovf_q, ovf_d;
	logic          fetch_s1, fetch_d;
	logic          chk_s1, chk_d;
	logic [AW-1:0] jaddr_s1, jaddr_d;
	logic          emit_s1, emit_d;
	logic          elast_s1, elast_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rkes_pkg::S_LOAD;
			count_q  <= '0;
			n_q      <= '0;
			i_q      <= '0;
			j_q      <= '0;
			ovf_q    <= 1'b0;
			fetch_s1 <= 1'b0;
			chk_s1   <= 1'b0;
			jaddr_s1 <= '0;
			emit_s1  <= 1'b0;
			elast_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			n_q      <= n_d;
			i_q      <= i_d;
			j_q      <= j_d;
			ovf_q    <= ovf_d;
			fetch_s1 <= fetch_d;
			chk_s1   <= chk_d;
			jaddr_s1 <= jaddr_d;
			emit_s1  <= emit_d;
			elast_s1 <= elast_d;
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		n_d     = n_q;
		i_d     = i_q;
		j_d     = j_q;
		ovf_d   = ovf_q;
		fetch_d = 1'b0;
		chk_d   = 1'b0;
		jaddr_d = jaddr_s1;
		emit_d  = 1'b0;
		elast_d = 1'b0;
		rd_addr = j_q[AW-1:0];
		wr_addr = count_q[AW-1:0];
		cmd          = '0;
		cmd.load_cur = fetch_s1;
		cmd.cmp      = chk_s1;
		cmd.emit     = emit_s1;
		cmd.last     = elast_s1;
		cmd.ovf      = ovf_q;
		busy = (state_q != rkes_pkg::S_LOAD);

		unique case (state_q)
			rkes_pkg::S_LOAD: begin
				cmd.wr_load = 1'b1;
				if (start) begin
					if (count_q < CW'(MAX_ITEMS)) begin
						cmd.wr_en = 1'b1;
						count_d   = count_q + CW'(1);
					end else begin
						ovf_d = 1'b1;
					end
					if (last) begin
						n_d = count_d;
						i_d = '0;
						j_d = '0;
						state_d = (count_d < CW'(2)) ? rkes_pkg::S_EMIT : rkes_pkg::S_FETCH;
					end
				end
			end
			rkes_pkg::S_FETCH: begin
				rd_addr = i_q[AW-1:0];
				fetch_d = 1'b1;
				j_d     = i_q + CW'(1);
				state_d = rkes_pkg::S_SCAN;
			end
			rkes_pkg::S_SCAN: begin
				// A swap writes the held record back to the slot read in the previous cycle.
				if (chk_s1) begin
					wr_addr   = jaddr_s1;
					cmd.wr_en = swap;
				end
				if (j_q < n_q) begin
					rd_addr = j_q[AW-1:0];
					chk_d   = 1'b1;
					jaddr_d = j_q[AW-1:0];
					j_d     = j_q + CW'(1);
				end else if (!chk_s1) begin
					state_d = rkes_pkg::S_STORE;
				end
			end
			rkes_pkg::S_STORE: begin
				wr_addr   = i_q[AW-1:0];
				cmd.wr_en = 1'b1;
				i_d       = i_q + CW'(1);
				if ((CW+1)'(i_q) + (CW+1)'(2) < (CW+1)'(n_q)) begin
					state_d = rkes_pkg::S_FETCH;
				end else begin
					j_d     = '0;
					state_d = rkes_pkg::S_EMIT;
				end
			end
			rkes_pkg::S_EMIT: begin
				if (j_q < n_q) begin
					rd_addr = j_q[AW-1:0];
					emit_d  = 1'b1;
					elast_d = ((CW+1)'(j_q) + (CW+1)'(1) == (CW+1)'(n_q));
					j_d     = j_q + CW'(1);
				end else begin
					count_d = '0;
					ovf_d   = 1'b0;
					state_d = rkes_pkg::S_LOAD;
				end
			end
			default: begin
				state_d = rkes_pkg::S_LOAD;
			end
		endcase
	end

endmodule

// ----- src/record_key_exchange_sorter_unit.sv -----
// Top level of the record key exchange sorter.
// Depends on rkes_pkg, rkes_ctrl, rkes_dp (and through it rkes_ram).
//
// Usage: records (key, tag, last) are taken at a clock edge where start is
// high and busy is low, one per cycle while loading. Up to MAX_ITEMS records
// are kept; later ones are dropped and the run is flagged as overflowed.
// A record with last set (kept or dropped) closes the set: busy rises and the
// stored records are sorted by signed key, ascending, or descending when the
// descending register is set (written through cfg_valid/cfg_ready/cfg_data,
// always ready; the user must write it only while the block is idle, which
// the block itself does not enforce). Sorting holds one record in a register
// and scans the later slots through the single read port of the record RAM,
// one compare-and-swap per cycle. The results then follow, one per cycle,
// each on result_valid for exactly one cycle, with last_out on the final
// one; busy falls as the final beat is produced. The receiver cannot stall
// the results. Reset (arst_n low) empties the set, clears the overflow flag
// and selects ascending order; the RAM contents are not cleared.
module record_key_exchange_sorter_unit #(
	parameter int MAX_ITEMS = rkes_pkg::MAX_ITEMS_DEF,
	localparam int AW = $clog2(MAX_ITEMS)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [rkes_pkg::KEY_W-1:0] key,
	input  logic        [rkes_pkg::TAG_W-1:0] tag,
	input  logic                              last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_data,
	output logic                              result_valid,
	output logic signed [rkes_pkg::KEY_W-1:0] sorted_key,
	output logic        [rkes_pkg::TAG_W-1:0] sorted_tag,
	output logic                              last_out,
	output logic                              overflowed
);

	logic           swap;
	logic [AW-1:0]  rd_addr;
	logic [AW-1:0]  wr_addr;
	rkes_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	rkes_ctrl #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.swap   (swap),
		.busy   (busy),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.cmd    (cmd)
	);

	rkes_dp #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_desc    (cfg_data),
		.key         (key),
		.tag         (tag),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.cmd         (cmd),
		.swap        (swap),
		.result_valid(result_valid),
		.sorted_key  (sorted_key),
		.sorted_tag  (sorted_tag),
		.last_out    (last_out),
		.overflowed  (overflowed)
	);

	// A closing record always starts a sort or an emit pass.
	a_last_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last |=> busy)
		else $error("closing record did not start a run");

	// Results only come out of a run that was in progress in the previous cycle.
	a_result_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result beat outside a run");

	// A final result beat is never followed directly by another final beat.
	a_last_on_beat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_out |=> !(result_valid && last_out))
		else $error("two final beats in a row");

	// A swap is only raised during a compare step.
	a_swap_on_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		swap |-> cmd.cmp && busy)
		else $error("swap outside a compare step");

endmodule
